>>> design/lrb_pkg.sv
// Shared types and constants for the LRU temporary register binder.
package lrb_pkg;

  // Fixed port widths of the request and result fields.
  localparam int VAR_ID_W    = 16;
  localparam int REG_INDEX_W = 3;

  // Intermediate widths that cover every legal ID_BITS and register count.
  localparam int ID_EXT_W  = 32;
  localparam int REG_EXT_W = 8;

  // Request function codes.
  localparam logic FUNC_ASSIGN = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request fields on a transfer
    logic execute;  // look up, update the bindings and load the result
  } ctrl_cmd_t;

endpackage

>>> design/lrb_ctrl.sv
// Controller state machine for the LRU temporary register binder.
module lrb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output lrb_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_EXEC;
            busy_r  <= 1'b1;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_IDLE;
          busy_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.capture = start && !busy_r;
  assign cmd.execute = (state_r == ST_EXEC);
  assign busy        = busy_r;
  assign out_valid   = out_valid_r;

endmodule

>>> design/lrb_dp.sv
// Datapath of the LRU temporary register binder: tag table, recency order and result registers.
module lrb_dp #(
  parameter int NUM_TEMP_REGS = 8,
  parameter int ID_BITS       = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrb_pkg::ctrl_cmd_t                  cmd,
  input  logic                                in_func,
  input  logic [lrb_pkg::VAR_ID_W-1:0]        in_var_id,
  input  logic                                in_load_needed,
  output logic [lrb_pkg::REG_INDEX_W-1:0]     out_reg_index,
  output logic                                out_hit,
  output logic                                out_load_request,
  output logic                                out_evict_valid,
  output logic [lrb_pkg::VAR_ID_W-1:0]        out_evict_var_id
);

  localparam int REG_BITS  = $clog2(NUM_TEMP_REGS);
  localparam int LEN_BITS  = $clog2(NUM_TEMP_REGS + 1);
  localparam int ID_EXT_W  = lrb_pkg::ID_EXT_W;
  localparam int REG_EXT_W = lrb_pkg::REG_EXT_W;
  localparam int VAR_ID_W  = lrb_pkg::VAR_ID_W;
  localparam int IDX_W     = lrb_pkg::REG_INDEX_W;
  localparam logic [LEN_BITS-1:0] LEN_FULL = LEN_BITS'(NUM_TEMP_REGS);
  localparam logic [REG_BITS-1:0] LAST_POS = REG_BITS'(NUM_TEMP_REGS - 1);

  // Captured request.
  logic                func_r;
  logic [ID_BITS-1:0]  id_r;
  logic                load_r;

  // Binding state.
  logic [ID_BITS-1:0]  tag_r   [NUM_TEMP_REGS];
  logic [NUM_TEMP_REGS-1:0] valid_r;
  logic [REG_BITS-1:0] order_r [NUM_TEMP_REGS];
  logic [LEN_BITS-1:0] len_r;

  // Result registers.
  logic [IDX_W-1:0]    reg_index_r;
  logic                hit_r;
  logic                load_req_r;
  logic                evict_valid_r;
  logic [VAR_ID_W-1:0] evict_id_r;

  // Lookup and update logic.
  logic [ID_EXT_W-1:0]      id_ext;
  logic [NUM_TEMP_REGS-1:0] match_vec;
  logic                     hit;
  logic [REG_BITS-1:0]      hit_reg;
  logic                     free;
  logic [REG_BITS-1:0]      free_reg;
  logic                     ord_found;
  logic [REG_BITS-1:0]      ord_pos;
  logic [REG_BITS-1:0]      sel_reg;
  logic [REG_BITS-1:0]      sel_pos;
  logic                     in_order;
  logic                     evict;
  logic [LEN_BITS-1:0]      len_nxt;
  logic [REG_BITS-1:0]      order_nxt [NUM_TEMP_REGS];
  logic [REG_EXT_W-1:0]     sel_reg_ext;
  logic [ID_EXT_W-1:0]      evict_tag_ext;

  assign id_ext = ID_EXT_W'(in_var_id);

  always_comb begin
    hit       = 1'b0;
    hit_reg   = '0;
    free      = 1'b0;
    free_reg  = '0;
    ord_found = 1'b0;
    ord_pos   = '0;
    for (int i = 0; i < NUM_TEMP_REGS; i++) begin
      match_vec[i] = valid_r[i] && (tag_r[i] == id_r);
    end
    // Scanning downward leaves the lowest-numbered candidate selected.
    for (int i = NUM_TEMP_REGS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit     = 1'b1;
        hit_reg = REG_BITS'(i);
      end
      if (!valid_r[i]) begin
        free     = 1'b1;
        free_reg = REG_BITS'(i);
      end
    end
    for (int i = NUM_TEMP_REGS - 1; i >= 0; i--) begin
      if ((order_r[i] == hit_reg) && (LEN_BITS'(i) < len_r)) begin
        ord_found = 1'b1;
        ord_pos   = REG_BITS'(i);
      end
    end
  end

  always_comb begin
    evict    = 1'b0;
    in_order = 1'b0;
    sel_pos  = '0;
    len_nxt  = len_r;
    if (hit) begin
      sel_reg  = hit_reg;
      in_order = ord_found;
      sel_pos  = ord_pos;
    end else if (free) begin
      sel_reg = free_reg;
    end else begin
      // Every register is bound: the tail of the order is the victim.
      evict    = 1'b1;
      sel_reg  = order_r[NUM_TEMP_REGS-1];
      in_order = 1'b1;
      sel_pos  = LAST_POS;
    end
    if (!in_order) begin
      if (len_r < LEN_FULL) begin
        len_nxt = len_r + LEN_BITS'(1);
        sel_pos = REG_BITS'(len_r);
      end else begin
        sel_pos = LAST_POS;
      end
    end
    order_nxt[0] = sel_reg;
    for (int i = 1; i < NUM_TEMP_REGS; i++) begin
      if (REG_BITS'(i) <= sel_pos) begin
        order_nxt[i] = order_r[i-1];
      end else begin
        order_nxt[i] = order_r[i];
      end
    end
  end

  assign sel_reg_ext   = REG_EXT_W'(sel_reg);
  assign evict_tag_ext = ID_EXT_W'(tag_r[sel_reg]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      len_r   <= '0;
    end else if (cmd.execute) begin
      if (func_r == lrb_pkg::FUNC_CLEAR) begin
        valid_r <= '0;
        len_r   <= '0;
      end else begin
        valid_r[sel_reg] <= 1'b1;
        len_r            <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      id_r   <= id_ext[ID_BITS-1:0];
      load_r <= in_load_needed;
    end
    if (cmd.execute) begin
      if (func_r == lrb_pkg::FUNC_CLEAR) begin
        reg_index_r   <= '0;
        hit_r         <= 1'b0;
        load_req_r    <= 1'b0;
        evict_valid_r <= 1'b0;
        evict_id_r    <= '0;
      end else begin
        tag_r[sel_reg] <= id_r;
        order_r        <= order_nxt;
        reg_index_r    <= sel_reg_ext[IDX_W-1:0];
        hit_r          <= hit;
        load_req_r     <= !hit && load_r;
        evict_valid_r  <= evict;
        evict_id_r     <= evict ? evict_tag_ext[VAR_ID_W-1:0] : '0;
      end
    end
  end

  assign out_reg_index    = reg_index_r;
  assign out_hit          = hit_r;
  assign out_load_request = load_req_r;
  assign out_evict_valid  = evict_valid_r;
  assign out_evict_var_id = evict_id_r;

endmodule

>>> design/lru_temp_register_binder.sv
// Top level of the LRU temporary register binder.
//
// Binds variable identifiers to NUM_TEMP_REGS temporary registers, fully
// associative, with least recently used replacement.
// Request channel: a transfer happens at a rising edge where start is high
// and busy is low; in_func selects assign or clear, in_var_id is the
// identifier (low ID_BITS bits used) and in_load_needed asks for a load.
// Result channel: out_valid is high for exactly one cycle with the result on
// the out_ ports; the receiver cannot stall, so results are never held.
// Busy is high during the execute cycle of a request and the result cycle
// follows it. A new request may be transferred in the result cycle, but not
// while busy, so the block takes no new request before the last one is in
// its result cycle. The cost is the execute cycle, where the tag table is
// compared in parallel and the recency order is shifted before the next
// lookup.
// A miss with no free register evicts the tail of the recency order and
// reports its old identifier on out_evict_var_id.
// Reset (rst_n low, synchronous) unbinds every register and empties the
// recency order; no clearing pass is needed.
module lru_temp_register_binder #(
  parameter int NUM_TEMP_REGS = 8,
  parameter int ID_BITS       = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [lrb_pkg::VAR_ID_W-1:0]    in_var_id,
  input  logic                            in_load_needed,
  output logic                            out_valid,
  output logic [lrb_pkg::REG_INDEX_W-1:0] out_reg_index,
  output logic                            out_hit,
  output logic                            out_load_request,
  output logic                            out_evict_valid,
  output logic [lrb_pkg::VAR_ID_W-1:0]    out_evict_var_id
);

  lrb_pkg::ctrl_cmd_t cmd;

  lrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  lrb_dp #(
    .NUM_TEMP_REGS (NUM_TEMP_REGS),
    .ID_BITS       (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_var_id        (in_var_id),
    .in_load_needed   (in_load_needed),
    .out_reg_index    (out_reg_index),
    .out_hit          (out_hit),
    .out_load_request (out_load_request),
    .out_evict_valid  (out_evict_valid),
    .out_evict_var_id (out_evict_var_id)
  );

endmodule
